@@ design/unsorted_array_priority_queue_unit_assert.svh @@
// Assertion macros used by the queue's top-level RTL.
`ifndef UNSORTED_ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define UNSORTED_ARRAY_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define UPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define UPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/upq_pkg.sv @@
`default_nettype none
package upq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 8;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_PEEK   = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] in_value;
      logic [7:0]         in_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_value;
      logic [7:0]         out_priority;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [7:0]         prio;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT
   } state_type;

endpackage
`default_nettype wire

@@ design/unsorted_array_priority_queue_unit.sv @@
// Unsorted priority queue of up to QUEUE_DEPTH (value, priority) pairs held in one
// synchronous RAM. A command is taken on a clock edge with start high and busy low;
// its single result appears on rsp_data for exactly one cycle with rsp_strobe high,
// and the receiver cannot stall it. Insert, an unused mode, and peek or delete on an
// empty queue give their result on the cycle after start and never raise busy. Peek
// scans the stored entries one RAM read per cycle with busy high, result on the cycle
// after. Delete scans the same way and then moves each later entry down one slot, one
// read and one write per cycle, with busy high throughout. On ties the most recently
// inserted entry wins.
`default_nettype none
`include "unsorted_array_priority_queue_unit_assert.svh"
module unsorted_array_priority_queue_unit #(
   parameter int QUEUE_DEPTH = upq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  upq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output upq_pkg::rsp_type rsp_data
);
   import upq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   entry_type     mem_rd_data;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   entry_type     mem_wr_data;

   upq_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   upq_mem #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   `UPQ_ASSERT_NEXT(a_insert_answers,
      start && !busy && (req_data.mode == MODE_INSERT), rsp_strobe,
      "insert gave no result beat on the next cycle")
   `UPQ_ASSERT_NOW(a_beat_when_idle, rsp_strobe, !busy,
      "result beat while a command is still running")
   `UPQ_ASSERT_NOW(a_done_gives_beat, $fell(busy), rsp_strobe,
      "command finished without a result beat")
   `UPQ_ASSERT_NOW(a_full_zero_payload, rsp_strobe && (rsp_data.status != STATUS_OK),
      (rsp_data.out_value == 0) && (rsp_data.out_priority == 0),
      "error beat carries nonzero payload")

endmodule
`default_nettype wire

@@ design/upq_mem.sv @@
`default_nettype none
module upq_mem #(
   parameter int QUEUE_DEPTH = upq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   output upq_pkg::entry_type             rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   input  upq_pkg::entry_type             wr_data
);
   import upq_pkg::*;

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ design/upq_ctrl.sv @@
`default_nettype none
module upq_ctrl #(
   parameter int QUEUE_DEPTH = upq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  upq_pkg::req_type               req_data,
   output logic                           rsp_strobe,
   output upq_pkg::rsp_type               rsp_data,
   output logic                           mem_rd_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] mem_rd_addr,
   input  upq_pkg::entry_type             mem_rd_data,
   output logic                           mem_wr_en,
   output logic [$clog2(QUEUE_DEPTH)-1:0] mem_wr_addr,
   output upq_pkg::entry_type             mem_wr_data
);
   import upq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [7:0]         top_ff, top_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic signed [31:0] best_val_ff, best_val_in;
   logic               del_ff, del_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               scan_op;
   logic               empty;
   logic               full;
   logic               scan_last;
   logic               shift_last;
   logic               take_new;
   logic [AW-1:0]      fin_idx;
   logic signed [31:0] fin_val;
   logic [7:0]         fin_pri;
   logic               need_shift;

   assign accept     = start && (state_ff == ST_IDLE);
   assign scan_op    = (req_data.mode == MODE_PEEK) || (req_data.mode == MODE_DELETE);
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign scan_last  = ((idx_ff + CW'(1)) == count_ff);
   assign shift_last = ((idx_ff + CW'(2)) == count_ff);
   // ties go to the later entry
   assign take_new   = (mem_rd_data.prio >= top_ff);
   assign fin_idx    = take_new ? AW'(idx_ff) : best_idx_ff;
   assign fin_val    = take_new ? mem_rd_data.value : best_val_ff;
   assign fin_pri    = take_new ? mem_rd_data.prio : top_ff;
   assign need_shift = del_ff && ((CW'(fin_idx) + CW'(1)) != count_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && scan_op && !empty) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = need_shift ? ST_SHIFT : ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (shift_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      top_in        = top_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      del_in        = del_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = mem_rd_data;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{status: STATUS_OK, out_value: '0, out_priority: '0};
               unique case (req_data.mode)
                  MODE_INSERT: begin
                     if (full) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(count_ff);
                        mem_wr_data = '{value: req_data.in_value, prio: req_data.in_priority};
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  MODE_PEEK, MODE_DELETE: begin
                     if (empty) begin
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        // hold the result until the scan ends
                        rsp_strobe_in = 1'b0;
                        mem_rd_en     = 1'b1;
                        mem_rd_addr   = '0;
                        idx_in        = '0;
                        top_in        = '0;
                        best_idx_in   = '0;
                        best_val_in   = '0;
                        del_in        = (req_data.mode == MODE_DELETE);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            top_in      = fin_pri;
            best_val_in = fin_val;
            best_idx_in = fin_idx;
            if (!scan_last) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(idx_ff + CW'(1));
               idx_in      = idx_ff + CW'(1);
            end else if (need_shift) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(CW'(fin_idx) + CW'(1));
               idx_in      = CW'(fin_idx);
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{status: STATUS_OK, out_value: fin_val, out_priority: fin_pri};
               if (del_ff) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end
         ST_SHIFT: begin
            // move the entry read last cycle down one slot
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(idx_ff);
            mem_wr_data = mem_rd_data;
            if (shift_last) begin
               count_in      = count_ff - CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{status: STATUS_OK, out_value: best_val_ff,
                                 out_priority: top_ff};
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(idx_ff + CW'(2));
               idx_in      = idx_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      top_ff      <= top_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      del_ff      <= del_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

@@ test/unsorted_array_priority_queue_unit_test.sv @@
`timescale 1ns / 100ps
module unsorted_array_priority_queue_unit_test;
   import upq_pkg::*;

   localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_COMMANDS = 1000;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 4 * DEPTH + 8;
   localparam int QUIET_FIRST = 400;
   localparam int QUIET_LAST = 600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;

   unsorted_array_priority_queue_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // Shadow copy of the queue contents, in arrival order.
   logic signed [31:0] shadow_values [DEPTH];
   logic [7:0] shadow_prios [DEPTH];
   int shadow_count = 0;

   req_type command_queue[$];
   rsp_type expected_responses[$];

   int error_count = 0;
   int cycle_count = 0;
   int accepted_total = 0;
   int insert_count = 0;
   int full_count = 0;
   int peek_count = 0;
   int delete_count = 0;
   int empty_count = 0;
   int unused_count = 0;
   int filled_count = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic rsp_type predict_response(input req_type cmd);
      rsp_type r;
      int best;
      logic [7:0] top;
      r = '0;
      case (cmd.mode)
         MODE_INSERT: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_values[shadow_count] = cmd.in_value;
               shadow_prios[shadow_count] = cmd.in_priority;
               shadow_count++;
            end
         end
         MODE_PEEK, MODE_DELETE: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               best = 0;
               top = 8'd0;
               // ties go to the later entry
               for (int k = 0; k < shadow_count; k++) begin
                  if (shadow_prios[k] >= top) begin
                     top = shadow_prios[k];
                     best = k;
                  end
               end
               r.out_value = shadow_values[best];
               r.out_priority = shadow_prios[best];
               if (cmd.mode == MODE_DELETE) begin
                  for (int j = best; j + 1 < shadow_count; j++) begin
                     shadow_values[j] = shadow_values[j + 1];
                     shadow_prios[j] = shadow_prios[j + 1];
                  end
                  shadow_count--;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_command(input logic [1:0] mode, input logic signed [31:0] value,
                              input logic [7:0] prio);
      req_type c;
      c.mode = mode;
      c.in_value = value;
      c.in_priority = prio;
      command_queue.push_back(c);
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endtask

   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      v = $urandom;
      if ($urandom_range(0, 99) < 10) begin
         case ($urandom_range(0, 3))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2: v = 32'sh0000_0000;
            default: v = -32'sd1;
         endcase
      end
      return v;
   endfunction

   // Command driver: hold a beat while busy, otherwise launch the next one or idle.
   always @(posedge clock) begin : drive_commands
      rsp_type predicted;
      req_type filler;
      logic idle;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted = predict_response(req_data);
            expected_responses.push_back(predicted);
            case (req_data.mode)
               MODE_INSERT: begin
                  insert_count++;
                  if (predicted.status == STATUS_FULL) full_count++;
                  else if (shadow_count == DEPTH) filled_count++;
               end
               MODE_PEEK: peek_count++;
               MODE_DELETE: delete_count++;
               default: unused_count++;
            endcase
            if (predicted.status == STATUS_EMPTY) empty_count++;
            void'(command_queue.pop_front());
            accepted_total++;
         end
         if (!(start && busy)) begin
            idle = !(accepted_total >= QUIET_FIRST && accepted_total < QUIET_LAST)
                   && ($urandom_range(0, 99) < 32);
            if (command_queue.size() != 0 && !idle) begin
               start <= 1'b1;
               req_data <= command_queue[0];
            end else begin
               // scramble the payload while start is low
               filler.mode = 2'($urandom_range(0, 3));
               filler.in_value = $urandom;
               filler.in_priority = 8'($urandom_range(0, 255));
               start <= 1'b0;
               req_data <= filler;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_responses.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, got %0h", $time, rsp_data);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_data.status));
            if (rsp_data.out_value !== want.out_value)
               report_mismatch("out_value", want.out_value, rsp_data.out_value);
            if (rsp_data.out_priority !== want.out_priority)
               report_mismatch("out_priority", 32'(want.out_priority),
                               32'(rsp_data.out_priority));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : run_sequence
      int counted;
      int burst_len;
      int insert_weight;
      int prio_style;
      int roll;
      logic [7:0] prio;

      // directed: empty queue, unused mode, field extremes, ties, full queue, drain
      add_command(MODE_PEEK, 32'sd5, 8'd9);
      add_command(MODE_DELETE, -32'sd1, 8'hff);
      add_command(MODE_UNUSED, -32'sd1, 8'hff);
      add_command(MODE_INSERT, 32'sh8000_0000, 8'd0);
      add_command(MODE_PEEK, 32'sd0, 8'd0);
      add_command(MODE_INSERT, 32'sh7fff_ffff, 8'd255);
      add_command(MODE_INSERT, 32'sd0, 8'd255);
      add_command(MODE_INSERT, -32'sd1, 8'd0);
      add_command(MODE_INSERT, 32'sd1, 8'd255);
      add_command(MODE_INSERT, 32'sh5555_5555, 8'haa);
      add_command(MODE_INSERT, 32'shaaaa_aaaa, 8'h55);
      add_command(MODE_INSERT, -32'sd2, 8'd254);
      add_command(MODE_INSERT, 32'sd123, 8'd255);
      add_command(MODE_PEEK, 32'sd0, 8'd0);
      add_command(MODE_DELETE, 32'sd0, 8'd0);
      add_command(MODE_DELETE, 32'sd0, 8'd0);
      add_command(MODE_DELETE, 32'sd0, 8'd0);
      add_command(MODE_UNUSED, 32'sh1234_5678, 8'h5a);
      add_command(MODE_PEEK, 32'sd0, 8'd0);
      repeat (6) add_command(MODE_DELETE, 32'sd0, 8'd0);

      // random bursts that lean toward filling or draining the queue, or stay balanced
      counted = 0;
      while (counted < RANDOM_COMMANDS) begin
         burst_len = $urandom_range(8, 24);
         case ($urandom_range(0, 2))
            0: insert_weight = 15;
            1: insert_weight = 50;
            default: insert_weight = 85;
         endcase
         prio_style = $urandom_range(0, 2);
         repeat (burst_len) begin
            case (prio_style)
               0: prio = 8'($urandom_range(0, 255));
               1: prio = 8'($urandom_range(0, 3));
               default: begin
                  case ($urandom_range(0, 3))
                     0: prio = 8'd0;
                     1: prio = 8'd1;
                     2: prio = 8'd254;
                     default: prio = 8'd255;
                  endcase
               end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               add_command(MODE_UNUSED, pick_value(), prio);
            end else begin
               if (roll < 3 + insert_weight)
                  add_command(MODE_INSERT, pick_value(), prio);
               else if ($urandom_range(0, 2) == 0)
                  add_command(MODE_PEEK, pick_value(), prio);
               else
                  add_command(MODE_DELETE, pick_value(), prio);
               counted++;
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (command_queue.size() != 0) @(posedge clock);
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands in %0d cycles: %0d inserts (%0d refused, %0d filled)",
               accepted_total, cycle_count, insert_count, full_count, filled_count);
      $display("  %0d peeks, %0d deletes, %0d on an empty queue, %0d unused mode",
               peek_count, delete_count, empty_count, unused_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
